// ----- rtl/fem_pkg.sv -----
// Shared types and constants for the file extent map.
package fem_pkg;

  localparam int BLK_W       = 32;
  localparam int SIZE_W      = 44;
  // Rounded block count of a 44-bit byte size; enough for blocks of 512 bytes or more.
  localparam int KEEP_W      = 36;
  localparam int EXT_CNT_W   = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_LOOKUP   = 2'd0,
    CMD_APPEND   = 2'd1,
    CMD_TRUNCATE = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOOKUP,
    B_TRUNC
  } back_state_e;

  // Classified request as it travels through the queue.
  typedef struct packed {
    cmd_e              cmd;
    logic [BLK_W-1:0]  lblk;
    logic [BLK_W-1:0]  block_index;
    logic [KEEP_W-1:0] keep;
  } req_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_flags_t;

  typedef struct packed {
    logic                 valid;
    logic [BLK_W-1:0]     phys_block;
    logic                 found;
    status_e              status;
    logic [BLK_W-1:0]     freed_start;
    logic [BLK_W-1:0]     freed_count;
    logic [BLK_W-1:0]     blk_total;
    logic [EXT_CNT_W-1:0] extents_used;
    logic                 last;
  } result_t;

endpackage

// ----- rtl/fem_front.sv -----
// Front end: takes requests, rounds truncate sizes to blocks, feeds the queue.
module fem_front #(
  parameter int BLOCK_BYTES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [1:0]                      cmd_i,
  input  logic [fem_pkg::BLK_W-1:0]       logical_block_i,
  input  logic [fem_pkg::BLK_W-1:0]       block_index_i,
  input  logic [fem_pkg::SIZE_W-1:0]      new_size_i,
  input  fem_pkg::q_flags_t               q_flags_i,
  output logic                            busy_o,
  output logic                            push_o,
  output fem_pkg::req_t                   req_o
);

  localparam int DIVW  = fem_pkg::SIZE_W + 1;
  localparam int FLOG2 = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int DIG   = 4;
  localparam int NDIG  = (DIVW - FLOG2 + DIG - 1) / DIG;
  localparam int QW    = NDIG * DIG;
  localparam int PREW  = DIVW - QW;
  localparam int RW    = FLOG2 + 1;
  localparam int SW    = RW + DIG;
  localparam int CNTW  = $clog2(NDIG);
  localparam bit Pow2  = (BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0;
  localparam logic [DIVW-1:0] BbMinus1 = DIVW'(BLOCK_BYTES - 1);

  fem_pkg::front_state_e state_q, state_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic [QW-1:0]   sh_q, sh_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  fem_pkg::req_t   hold_q, hold_d;

  logic [DIVW-1:0] dividend;
  logic [SW-1:0]   rem_sh;
  logic [DIG-1:0]  digit;
  logic [SW-1:0]   digit_sub;
  logic            accept;
  fem_pkg::cmd_e   cmd_in;

  assign dividend = {1'b0, new_size_i} + BbMinus1;
  assign rem_sh   = {rem_q, sh_q[QW-1 -: DIG]};
  assign cmd_in   = fem_pkg::cmd_e'(cmd_i);
  assign accept   = start_i && !busy_o;

  // quotient digit: how many block sizes fit in the shifted remainder
  always_comb begin
    digit     = '0;
    digit_sub = '0;
    for (int k = 1; k < (1 << DIG); k++) begin
      if (rem_sh >= SW'(k * BLOCK_BYTES)) begin
        digit     = DIG'(k);
        digit_sub = SW'(k * BLOCK_BYTES);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    cnt_d   = cnt_q;
    hold_d  = hold_q;
    busy_o  = (state_q != fem_pkg::F_IDLE) || q_flags_i.full;
    push_o  = 1'b0;
    req_o   = hold_q;
    req_o.keep = fem_pkg::KEEP_W'(sh_q);
    unique case (state_q)
      fem_pkg::F_IDLE: begin
        if (accept) begin
          hold_d.cmd         = cmd_in;
          hold_d.lblk        = logical_block_i;
          hold_d.block_index = block_index_i;
          hold_d.keep        = fem_pkg::KEEP_W'(dividend >> FLOG2);
          if (cmd_in == fem_pkg::CMD_TRUNCATE && !Pow2) begin
            // radix-16 long division, top bits preloaded as they are below the divisor
            rem_d   = RW'(dividend[DIVW-1 -: PREW]);
            sh_d    = dividend[QW-1:0];
            cnt_d   = CNTW'(NDIG - 1);
            state_d = fem_pkg::F_DIV;
          end else begin
            push_o = 1'b1;
            req_o  = hold_d;
          end
        end
      end
      fem_pkg::F_DIV: begin
        rem_d = RW'(rem_sh - digit_sub);
        sh_d  = {sh_q[QW-DIG-1:0], digit};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = fem_pkg::F_PUSH;
        end
      end
      fem_pkg::F_PUSH: begin
        if (!q_flags_i.full) begin
          push_o  = 1'b1;
          state_d = fem_pkg::F_IDLE;
        end
      end
      default: begin
        state_d = fem_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fem_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    cnt_q  <= cnt_d;
    hold_q <= hold_d;
  end

endmodule

// ----- rtl/fem_queue.sv -----
// Short request queue between front and back end.
module fem_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fem_pkg::req_t     req_i,
  input  logic              pop_i,
  output fem_pkg::req_t     head_o,
  output fem_pkg::q_flags_t flags_o
);

  localparam int Depth = fem_pkg::QUEUE_DEPTH;
  localparam int PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(Depth + 1);

  fem_pkg::req_t   mem_q [Depth];
  logic [PW-1:0]   wr_q, wr_d;
  logic [PW-1:0]   rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign head_o            = mem_q[rd_q];
  assign flags_o.full      = cnt_q == CW'(Depth);
  assign flags_o.not_empty = cnt_q != '0;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= req_i;
    end
  end

endmodule

// ----- rtl/fem_back.sv -----
// Back end: holds the extent table and walks it for each queued request.
module fem_back #(
  parameter int MAX_EXTENTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fem_pkg::q_flags_t q_flags_i,
  input  fem_pkg::req_t     head_i,
  output logic              pop_o,
  output fem_pkg::result_t  res_o
);

  localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int NW = $clog2(MAX_EXTENTS + 1);
  localparam int TW = fem_pkg::BLK_W + $clog2(MAX_EXTENTS);
  localparam int CW = ((TW > fem_pkg::KEEP_W) ? TW : fem_pkg::KEEP_W) + 1;
  localparam logic [NW-1:0] NMax = NW'(MAX_EXTENTS);

  typedef logic [fem_pkg::BLK_W-1:0] blk_t;

  fem_pkg::back_state_e state_q, state_d;
  blk_t             start_q [MAX_EXTENTS];
  blk_t             len_q   [MAX_EXTENTS];
  logic [NW-1:0]    n_q, n_d;
  logic [TW-1:0]    total_q, total_d;
  fem_pkg::req_t    cur_q, cur_d;
  logic [IW-1:0]    i_q, i_d;
  logic [TW-1:0]    pos_q, pos_d;
  logic [NW-1:0]    nold_q, nold_d;
  logic             cut_q, cut_d;
  fem_pkg::result_t res_q, res_d;

  logic [IW-1:0] last_idx, rd_idx, wr_idx;
  blk_t          rd_start, rd_len, wr_start, wr_len, kn;
  logic          wr_en, contig;
  logic [TW-1:0] end_pos;
  logic [CW-1:0] keep_c, pos_c, end_c;

  assign last_idx = IW'(n_q - 1'b1);
  assign rd_idx   = (state_q == fem_pkg::B_IDLE) ? last_idx : i_q;
  assign rd_start = start_q[rd_idx];
  assign rd_len   = len_q[rd_idx];
  assign end_pos  = pos_q + TW'(rd_len);
  assign keep_c   = CW'(cur_q.keep);
  assign pos_c    = CW'(pos_q);
  assign end_c    = CW'(end_pos);
  assign kn       = cur_q.keep[fem_pkg::BLK_W-1:0] - pos_q[fem_pkg::BLK_W-1:0];
  // a run of all-ones length is never grown
  assign contig   = (n_q != '0) && (rd_len != '1) &&
                    (({1'b0, rd_start} + {1'b0, rd_len}) == {1'b0, head_i.block_index});
  assign res_o    = res_q;

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    total_d  = total_q;
    cur_d    = cur_q;
    i_d      = i_q;
    pos_d    = pos_q;
    nold_d   = nold_q;
    cut_d    = cut_q;
    pop_o    = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = i_q;
    wr_start = rd_start;
    wr_len   = rd_len;
    res_d    = '0;
    unique case (state_q)
      fem_pkg::B_IDLE: begin
        if (q_flags_i.not_empty) begin
          pop_o      = 1'b1;
          cur_d      = head_i;
          res_d.valid = 1'b1;
          res_d.last  = 1'b1;
          unique case (head_i.cmd)
            fem_pkg::CMD_LOOKUP: begin
              if (n_q == '0) begin
                res_d.status = fem_pkg::ST_MISS;
              end else begin
                res_d.valid = 1'b0;
                i_d         = '0;
                pos_d       = '0;
                state_d     = fem_pkg::B_LOOKUP;
              end
            end
            fem_pkg::CMD_APPEND: begin
              if (contig) begin
                wr_en   = 1'b1;
                wr_idx  = last_idx;
                wr_len  = rd_len + 1'b1;
                total_d = total_q + 1'b1;
              end else if (n_q < NMax) begin
                wr_en    = 1'b1;
                wr_idx   = IW'(n_q);
                wr_start = head_i.block_index;
                wr_len   = blk_t'(1);
                n_d      = n_q + 1'b1;
                total_d  = total_q + 1'b1;
              end else begin
                res_d.status = fem_pkg::ST_FULL;
              end
            end
            fem_pkg::CMD_CLEAR: begin
              n_d     = '0;
              total_d = '0;
            end
            fem_pkg::CMD_TRUNCATE: begin
              // nothing beyond the new size: one empty result
              if (CW'(head_i.keep) < CW'(total_q)) begin
                res_d.valid = 1'b0;
                i_d         = '0;
                pos_d       = '0;
                nold_d      = n_q;
                cut_d       = 1'b0;
                total_d     = TW'(head_i.keep);
                state_d     = fem_pkg::B_TRUNC;
              end
            end
            default: begin
              res_d.valid = 1'b0;
            end
          endcase
        end
      end
      fem_pkg::B_LOOKUP: begin
        if (CW'(cur_q.lblk) < end_c) begin
          res_d.valid      = 1'b1;
          res_d.last       = 1'b1;
          res_d.found      = 1'b1;
          res_d.phys_block = rd_start +
                             (cur_q.lblk - pos_q[fem_pkg::BLK_W-1:0]);
          state_d          = fem_pkg::B_IDLE;
        end else if (NW'(i_q) == n_q - 1'b1) begin
          res_d.valid  = 1'b1;
          res_d.last   = 1'b1;
          res_d.status = fem_pkg::ST_MISS;
          state_d      = fem_pkg::B_IDLE;
        end else begin
          i_d   = i_q + 1'b1;
          pos_d = end_pos;
        end
      end
      fem_pkg::B_TRUNC: begin
        // kept runs form a prefix, freed runs the suffix, so the table stays packed
        if (keep_c <= pos_c) begin
          res_d.valid       = 1'b1;
          res_d.freed_start = rd_start;
          res_d.freed_count = rd_len;
          if (!cut_q) begin
            n_d = NW'(i_q);
          end
          cut_d = 1'b1;
        end else if (end_c > keep_c) begin
          wr_en             = 1'b1;
          wr_len            = kn;
          res_d.valid       = 1'b1;
          res_d.freed_start = rd_start + kn;
          res_d.freed_count = rd_len - kn;
          n_d               = NW'(i_q) + 1'b1;
          cut_d             = 1'b1;
        end
        pos_d = end_pos;
        i_d   = i_q + 1'b1;
        if (NW'(i_q) == nold_q - 1'b1) begin
          res_d.last = 1'b1;
          state_d    = fem_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = fem_pkg::B_IDLE;
      end
    endcase
    res_d.blk_total    = total_d[fem_pkg::BLK_W-1:0];
    res_d.extents_used = fem_pkg::EXT_CNT_W'(n_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fem_pkg::B_IDLE;
      n_q         <= '0;
      total_q     <= '0;
      res_q.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      total_q <= total_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    i_q    <= i_d;
    pos_q  <= pos_d;
    nold_q <= nold_d;
    cut_q  <= cut_d;
    if (wr_en) begin
      start_q[wr_idx] <= wr_start;
      len_q[wr_idx]   <= wr_len;
    end
  end

endmodule

// ----- rtl/file_extent_map.sv -----
// Top level of the file extent map: front end, request queue and back end.
//
// Requests: a request is taken at a rising edge with start high and busy low.
// cmd_i selects lookup, append, truncate or clear; the other fields are read
// only by the command that needs them.
// Results: each result shows on the result ports for one cycle with
// result_valid_o high; last_o marks the final result of a request. The
// receiver cannot hold results off, and none is needed: the back end emits
// at most one result per cycle.
// Flow: append and clear pass through the queue and the back end's result
// register. A lookup walks the extents in order until one holds the block
// or none is left (up to MAX_EXTENTS). A truncate that cuts below the total
// walks every extent in use, one per cycle, freed runs leaving back to back.
// With a power-of-two BLOCK_BYTES the size rounds by a shift; otherwise the
// front end divides a truncate size four quotient bits a cycle, then queues
// it once the queue has room. The front end takes a new request while the
// back end works, unless it is dividing or the two-entry queue is full.
// Reset: the extent table is empty, the queue is empty and no result is
// pending; the table storage itself is not cleared, only its count.
module file_extent_map #(
  parameter int MAX_EXTENTS = 8,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic [1:0]                        cmd_i,
  input  logic [fem_pkg::BLK_W-1:0]         logical_block_i,
  input  logic [fem_pkg::BLK_W-1:0]         block_index_i,
  input  logic [fem_pkg::SIZE_W-1:0]        new_size_i,
  output logic                              busy,
  output logic                              result_valid_o,
  output logic [fem_pkg::BLK_W-1:0]         phys_block_o,
  output logic                              found_o,
  output logic [1:0]                        status_o,
  output logic [fem_pkg::BLK_W-1:0]         freed_start_o,
  output logic [fem_pkg::BLK_W-1:0]         freed_count_o,
  output logic [fem_pkg::BLK_W-1:0]         total_blocks_o,
  output logic [fem_pkg::EXT_CNT_W-1:0]     extents_used_o,
  output logic                              last_o
);

  fem_pkg::q_flags_t q_flags;
  fem_pkg::req_t     push_req;
  fem_pkg::req_t     head_req;
  fem_pkg::result_t  res;
  logic              push;
  logic              pop;

  // classify and round, one request at a time
  fem_front #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .cmd_i           (cmd_i),
    .logical_block_i (logical_block_i),
    .block_index_i   (block_index_i),
    .new_size_i      (new_size_i),
    .q_flags_i       (q_flags),
    .busy_o          (busy),
    .push_o          (push),
    .req_o           (push_req)
  );

  // decouples the divider from the extent walk
  fem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (push_req),
    .pop_i   (pop),
    .head_o  (head_req),
    .flags_o (q_flags)
  );

  // owns the extent table; results leave from its output register
  fem_back #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_flags_i (q_flags),
    .head_i    (head_req),
    .pop_o     (pop),
    .res_o     (res)
  );

  assign result_valid_o = res.valid;
  assign phys_block_o   = res.phys_block;
  assign found_o        = res.found;
  assign status_o       = res.status;
  assign freed_start_o  = res.freed_start;
  assign freed_count_o  = res.freed_count;
  assign total_blocks_o = res.blk_total;
  assign extents_used_o = res.extents_used;
  assign last_o         = res.last;

endmodule

// ----- rtl/fem_checker.sv -----
// Port-level checks for the file extent map, bound to the top level.
module fem_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          busy,
  input logic                          result_valid_o,
  input logic [fem_pkg::BLK_W-1:0]     phys_block_o,
  input logic                          found_o,
  input logic [1:0]                    status_o,
  input logic [fem_pkg::BLK_W-1:0]     freed_count_o,
  input logic                          last_o
);

  // freed runs of a truncate leave on consecutive cycles
  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("fem: gap inside a multi-result truncate");

  // only a truncate gives more than one result, each with blocks freed
  a_multi_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> freed_count_o != '0)
    else $error("fem: non-final result frees nothing");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == fem_pkg::ST_MISS |-> !found_o && phys_block_o == '0)
    else $error("fem: lookup miss carries a mapping");

  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && found_o |-> status_o == fem_pkg::ST_OK && freed_count_o == '0)
    else $error("fem: lookup hit with bad status or freed run");

  a_busy_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(busy))
    else $error("fem: busy unknown out of reset");

endmodule

bind file_extent_map fem_checker u_fem_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .phys_block_o   (phys_block_o),
  .found_o        (found_o),
  .status_o       (status_o),
  .freed_count_o  (freed_count_o),
  .last_o         (last_o)
);
